### design/pid_time_proportional_relay_defines.svh
// Assertion macros for the relay controller.
`ifndef PID_TIME_PROPORTIONAL_RELAY_DEFINES_SVH
`define PID_TIME_PROPORTIONAL_RELAY_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRTR_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");
`define PRTR_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define PRTR_ASSERT_IMP(lbl, clk, rst, a, c)
`define PRTR_ASSERT_NXT(lbl, clk, rst, a, c)
`endif

`endif

### design/prtr_pkg.sv
package prtr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MAX = 3'd5;

  localparam logic signed [15:0] SETPOINT_RST  = 16'sd0;
  localparam logic [15:0]        GAIN_P_RST    = 16'd512;
  localparam logic [15:0]        GAIN_I_RST    = 16'd128;
  localparam logic [15:0]        GAIN_D_RST    = 16'd2560;
  localparam logic [7:0]         DRIVE_MIN_RST = 8'd0;
  localparam logic [7:0]         DRIVE_MAX_RST = 8'd50;

  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] temperature;
  } in_t;

  typedef struct packed {
    logic        relay_on;
    logic [11:0] drive_level;
    logic        computed;
  } out_t;

endpackage

### design/prtr_stream_if.sv
interface prtr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/pid_time_proportional_relay.sv
// A sample passes through the input register and then the result register.
// Throughput: one sample per cycle while the result side is ready; the PID step, clamps and relay compare sit in one
// combinational pass between the input and result registers, state updated on that pass.
// Reset (rst, synchronous): both stages empty, integral, last temperature and period
// counter cleared, configuration registers back to their defaults.
`include "pid_time_proportional_relay_defines.svh"

module pid_time_proportional_relay (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prtr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [prtr_pkg::CfgDataW-1:0]     cfg_data,
  prtr_stream_if.sink                       sample,
  prtr_stream_if.source                     result
);

  // configuration
  logic signed [15:0] setpoint;
  logic [15:0]        gain_p;
  logic [15:0]        gain_i;
  logic [15:0]        gain_d;
  logic [7:0]         drive_min;
  logic [7:0]         drive_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= prtr_pkg::SETPOINT_RST;
      gain_p    <= prtr_pkg::GAIN_P_RST;
      gain_i    <= prtr_pkg::GAIN_I_RST;
      gain_d    <= prtr_pkg::GAIN_D_RST;
      drive_min <= prtr_pkg::DRIVE_MIN_RST;
      drive_max <= prtr_pkg::DRIVE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prtr_pkg::REG_SETPOINT:  setpoint  <= signed'(cfg_data);
        prtr_pkg::REG_GAIN_P:    gain_p    <= cfg_data;
        prtr_pkg::REG_GAIN_I:    gain_i    <= cfg_data;
        prtr_pkg::REG_GAIN_D:    gain_d    <= cfg_data;
        prtr_pkg::REG_DRIVE_MIN: drive_min <= cfg_data[7:0];
        prtr_pkg::REG_DRIVE_MAX: drive_max <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          s1_v;
  prtr_pkg::in_t s1;
  logic          out_v;
  prtr_pkg::out_t out_d;
  logic          adv;

  assign adv          = !out_v || result.ready;
  assign sample.ready = !s1_v || adv;
  assign result.valid = out_v;
  assign result.data  = out_d;

  // controller state
  logic [12:0]        integral_sum;
  logic signed [15:0] previous_temperature;
  logic [7:0]         period_counter;

  // upper bound is tested first; with crossed bounds, values above hi give hi, all others lo
  function automatic logic [11:0] clamp12(input logic signed [27:0] v,
                                          input logic [11:0] lo,
                                          input logic [11:0] hi);
    logic [11:0] r;
    if (v > signed'({16'd0, hi}))      r = hi;
    else if (v < signed'({16'd0, lo})) r = lo;
    else                               r = v[11:0];
    return r;
  endfunction

  logic [11:0]        lo;
  logic [11:0]        hi;
  logic signed [16:0] err;
  logic signed [16:0] dt;
  logic signed [33:0] prod_i;
  logic signed [33:0] prod_p;
  logic signed [33:0] prod_d;
  logic signed [34:0] pd;
  logic signed [27:0] sum_raw;
  logic [11:0]        sum_c;
  logic signed [27:0] level_raw;
  logic [11:0]        level;
  logic [7:0]         cnt_inc;
  logic [7:0]         period_counter_next;
  logic               relay;

  always_comb begin
    lo      = {drive_min, 4'd0};
    hi      = {drive_max, 4'd0};
    err     = {setpoint[15], setpoint} - {s1.temperature[15], s1.temperature};
    dt      = {s1.temperature[15], s1.temperature}
              - {previous_temperature[15], previous_temperature};
    prod_i  = err * signed'({1'b0, gain_i});
    prod_p  = err * signed'({1'b0, gain_p});
    prod_d  = dt * signed'({1'b0, gain_d});
    pd      = {prod_p[33], prod_p} - {prod_d[33], prod_d};
    // arithmetic drop of 8 bits is the floor division by 256
    sum_raw = signed'({15'd0, integral_sum}) + {{2{prod_i[33]}}, prod_i[33:8]};
    sum_c   = clamp12(sum_raw, lo, hi);
    level_raw = {pd[34], pd[34:8]} + signed'({16'd0, sum_c});
    level   = clamp12(level_raw, lo, hi);
    cnt_inc = period_counter + 8'd1;
    period_counter_next = (cnt_inc >= drive_max) ? 8'd0 : cnt_inc;
    relay   = {period_counter_next, 4'd0} <= level;
  end

  logic step;
  assign step = adv && s1_v && s1.sample_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v                 <= 1'b0;
      out_v                <= 1'b0;
      integral_sum         <= '0;
      previous_temperature <= '0;
      period_counter       <= '0;
    end else begin
      if (sample.ready) s1_v <= sample.valid;
      if (adv) out_v <= s1_v;
      if (step) begin
        integral_sum         <= {1'b0, sum_c};
        previous_temperature <= s1.temperature;
        period_counter       <= period_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) s1 <= sample.data;
    if (adv && s1_v) begin
      if (s1.sample_valid) begin
        out_d.relay_on    <= relay;
        out_d.drive_level <= level;
        out_d.computed    <= 1'b1;
      end else begin
        out_d.relay_on    <= 1'b0;
        out_d.drive_level <= '0;
        out_d.computed    <= 1'b0;
      end
    end
  end

  `PRTR_ASSERT_IMP(a_invalid_zero, clk, rst, out_v && !out_d.computed,
                   !out_d.relay_on && out_d.drive_level == 12'd0)
  `PRTR_ASSERT_NXT(a_invalid_keeps_state, clk, rst, adv && s1_v && !s1.sample_valid,
                   $stable(integral_sum) && $stable(period_counter))
  `PRTR_ASSERT_IMP(a_integral_range, clk, rst, 1'b1, integral_sum <= 13'd4080)
  `PRTR_ASSERT_NXT(a_result_follows_stage, clk, rst, adv && s1_v, out_v)

endmodule

### sim/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 100;
  // indexes past the last register; writes there must be dropped
  localparam logic [prtr_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [prtr_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [prtr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [prtr_pkg::CfgDataW-1:0] cfg_data = '0;

  prtr_stream_if #(.T(prtr_pkg::in_t)) sample_ch ();
  prtr_stream_if #(.T(prtr_pkg::out_t)) result_ch ();

  pid_time_proportional_relay dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  always #5 clk = ~clk;

  // controller copy: settings and state
  logic signed [15:0] sp = prtr_pkg::SETPOINT_RST;
  logic [15:0] kp = prtr_pkg::GAIN_P_RST;
  logic [15:0] ki = prtr_pkg::GAIN_I_RST;
  logic [15:0] kd = prtr_pkg::GAIN_D_RST;
  logic [7:0] floor_steps = prtr_pkg::DRIVE_MIN_RST;
  logic [7:0] period_steps = prtr_pkg::DRIVE_MAX_RST;
  logic [12:0] integ = '0;
  logic signed [15:0] last_temp = '0;
  logic [7:0] counter = '0;

  prtr_pkg::in_t samples_to_send[$];
  prtr_pkg::out_t expected_drive[$];

  int bad_fields = 0;
  int checked_ticks = 0;
  int relay_on_ticks = 0;
  int idle_ticks = 0;
  int settings_used = 0;
  int cycles = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one control tick; a valid sample updates the integral, last sample and period counter
  function automatic prtr_pkg::out_t pid_tick(prtr_pkg::in_t s);
    longint lo, hi, err, dtemp, acc, level;
    prtr_pkg::out_t r;
    r = '0;
    if (!s.sample_valid) return r;
    lo = longint'(floor_steps) * 16;
    hi = longint'(period_steps) * 16;
    err = longint'(sp) - longint'($signed(s.temperature));
    dtemp = longint'($signed(s.temperature)) - longint'(last_temp);
    // >>> on signed longint floors toward minus infinity
    acc = clamp(longint'(integ) + ((err * longint'(ki)) >>> 8), lo, hi);
    integ = acc[12:0];
    level = clamp(acc + ((err * longint'(kp) - dtemp * longint'(kd)) >>> 8), lo, hi);
    last_temp = s.temperature;
    counter = counter + 8'd1;
    if (counter >= period_steps) counter = '0;
    r.relay_on = (longint'(counter) * 16 <= level);
    r.drive_level = level[11:0];
    r.computed = 1'b1;
    return r;
  endfunction

  function automatic prtr_pkg::in_t mk(logic v, logic [15:0] t);
    prtr_pkg::in_t s;
    s.sample_valid = v;
    s.temperature = t;
    return s;
  endfunction

  function automatic prtr_pkg::in_t random_sample();
    prtr_pkg::in_t s;
    int unsigned pick;
    pick = $urandom_range(99);
    s.sample_valid = (pick >= 8);
    if (pick < 60)
      s.temperature = sp + 16'($urandom_range(640)) - 16'd320;
    else if (pick < 72)
      s.temperature = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else
      s.temperature = 16'($urandom);
    return s;
  endfunction

  // sender side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pid_time_proportional_relay test failed");
      $finish;
    end
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.data <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        expected_drive.push_back(pid_tick(sample_ch.data));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (samples_to_send.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
          sample_ch.data <= samples_to_send.pop_front();
          sample_ch.valid <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver side and result check
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_drive.size() == 0) begin
          $error("result transfer with nothing expected");
          bad_fields++;
        end else begin
          prtr_pkg::out_t want;
          want = expected_drive.pop_front();
          if (result_ch.data.relay_on !== want.relay_on) begin
            $error("relay_on expected %0d got %0d", want.relay_on, result_ch.data.relay_on);
            bad_fields++;
          end
          if (result_ch.data.drive_level !== want.drive_level) begin
            $error("drive_level expected %0d got %0d", want.drive_level,
                   result_ch.data.drive_level);
            bad_fields++;
          end
          if (result_ch.data.computed !== want.computed) begin
            $error("computed expected %0d got %0d", want.computed, result_ch.data.computed);
            bad_fields++;
          end
          checked_ticks++;
          if (want.relay_on) relay_on_ticks++;
          if (!want.computed) idle_ticks++;
        end
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || $urandom_range(99) >= 36;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || sample_ch.valid || expected_drive.size() != 0);
  endtask

  task automatic put_reg(input logic [prtr_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      prtr_pkg::REG_SETPOINT: sp = val;
      prtr_pkg::REG_GAIN_P: kp = val;
      prtr_pkg::REG_GAIN_I: ki = val;
      prtr_pkg::REG_GAIN_D: kd = val;
      prtr_pkg::REG_DRIVE_MIN: floor_steps = val[7:0];
      prtr_pkg::REG_DRIVE_MAX: period_steps = val[7:0];
      default: ;
    endcase
  endtask

  // only called once the block has drained
  task automatic program_regs(input logic [15:0] set_pt, p, i, d, input logic [7:0] lo, hi);
    put_reg(prtr_pkg::REG_SETPOINT, set_pt);
    put_reg(prtr_pkg::REG_GAIN_P, p);
    put_reg(prtr_pkg::REG_GAIN_I, i);
    put_reg(REG_SPARE_LO, 16'($urandom));
    put_reg(prtr_pkg::REG_GAIN_D, d);
    // junk in the upper byte of the 8-bit registers
    put_reg(prtr_pkg::REG_DRIVE_MIN, {8'($urandom), lo});
    put_reg(prtr_pkg::REG_DRIVE_MAX, {8'($urandom), hi});
    put_reg(REG_SPARE_HI, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_gain(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(span));
  endfunction

  initial begin
    int unsigned pick;
    logic [7:0] hi, lo;
    logic [15:0] set_pt;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: extremes, big temperature swings, failed readings
    samples_to_send.push_back(mk(1'b1, 16'd0));
    samples_to_send.push_back(mk(1'b1, 16'h7FFF));
    samples_to_send.push_back(mk(1'b1, 16'h8000));
    samples_to_send.push_back(mk(1'b1, 16'h7FFF));
    samples_to_send.push_back(mk(1'b0, 16'h8000));
    samples_to_send.push_back(mk(1'b0, 16'h7FFF));
    for (int k = 1; k <= 5; k++) samples_to_send.push_back(mk(1'b1, 16'(-16 * k)));
    samples_to_send.push_back(mk(1'b1, 16'h0010));
    wait_drained();

    // period shortened below the running counter
    program_regs(prtr_pkg::SETPOINT_RST, prtr_pkg::GAIN_P_RST, prtr_pkg::GAIN_I_RST,
                 prtr_pkg::GAIN_D_RST, prtr_pkg::DRIVE_MIN_RST, 8'd5);
    repeat (3) samples_to_send.push_back(mk(1'b1, 16'hFF9C));
    samples_to_send.push_back(mk(1'b1, 16'hFFFF));
    wait_drained();

    // lower bound above upper bound, full-scale gains
    program_regs(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd200, 8'd10);
    samples_to_send.push_back(mk(1'b1, 16'h8000));
    samples_to_send.push_back(mk(1'b1, 16'h7FFF));
    samples_to_send.push_back(mk(1'b1, 16'h0000));
    wait_drained();

    // zero-length period
    program_regs(16'h8000, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    samples_to_send.push_back(mk(1'b1, 16'h7FFF));
    samples_to_send.push_back(mk(1'b1, 16'h8000));
    samples_to_send.push_back(mk(1'b0, 16'h0005));
    wait_drained();

    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255);
    samples_to_send.push_back(mk(1'b1, 16'h5555));
    samples_to_send.push_back(mk(1'b1, 16'hAAAA));
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(19);
      hi = (pick < 3) ? 8'd255 : (pick < 5) ? 8'd0 : 8'($urandom_range(60, 1));
      pick = $urandom_range(9);
      lo = (pick < 6) ? 8'd0 : (pick < 8) ? 8'($urandom_range(hi)) : 8'($urandom_range(255));
      set_pt = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1600));
      program_regs(set_pt, random_gain(2048), random_gain(1024), random_gain(8192), lo, hi);
      calm = (phase == 2);
      hold_req = (phase == 5);
      for (int k = 0; k < PHASE_SAMPLES; k++) samples_to_send.push_back(random_sample());
      // sender waits here until every result is back
      wait_drained();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    $display("%0d control ticks checked over %0d register settings", checked_ticks,
             settings_used);
    $display("%0d failed readings, %0d ticks with the relay on", idle_ticks, relay_on_ticks);
    if (bad_fields == 0 && expected_drive.size() == 0)
      $display("pid_time_proportional_relay test passed");
    else
      $display("pid_time_proportional_relay test failed");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/prtr_pkg.sv
design/prtr_stream_if.sv
design/pid_time_proportional_relay.sv
sim/testbench.sv
